// ===== src/fru_pkg.sv =====
// Shared types, character constants and decode functions for the FRU field decoder.
package fru_pkg;

  // Field kinds carried in bits 7:6 of a header byte.
  localparam logic [1:0] KIND_BINARY = 2'd0;
  localparam logic [1:0] KIND_BCD    = 2'd1;
  localparam logic [1:0] KIND_ASCII6 = 2'd2;
  localparam logic [1:0] KIND_ASCII8 = 2'd3;

  localparam logic [5:0] LEN_MASK = 6'h3F;

  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_UPPERA = 8'h41;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_QUEST  = 8'h3F;

  localparam logic [3:0] NIB_NINE  = 4'h9;
  localparam logic [3:0] NIB_SPACE = 4'hA;
  localparam logic [3:0] NIB_DASH  = 4'hB;
  localparam logic [3:0] NIB_DOT   = 4'hC;

  // One result word.
  typedef struct packed {
    logic [7:0] ch;
    logic       valid;
    logic [1:0] kind;
    logic       last;
  } res_t;

  // Results produced by the decoder for one input byte.
  typedef struct packed {
    logic [1:0] count;
    res_t       r0;
    res_t       r1;
  } dec_out_t;

  function automatic logic [7:0] six_bit_char(input logic [5:0] v);
    return {2'b00, v} + CH_SPACE;
  endfunction

  function automatic logic [7:0] bcd_plus_char(input logic [3:0] nib);
    logic [7:0] c;
    priority if (nib <= NIB_NINE) c = CH_ZERO + {4'h0, nib};
    else if (nib == NIB_SPACE)    c = CH_SPACE;
    else if (nib == NIB_DASH)     c = CH_DASH;
    else if (nib == NIB_DOT)      c = CH_DOT;
    else                          c = CH_QUEST;
    return c;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib <= NIB_NINE) c = CH_ZERO + {4'h0, nib};
    else                 c = CH_UPPERA + {4'h0, nib} - {4'h0, NIB_SPACE};
    return c;
  endfunction

endpackage

// ===== src/fru_decode.sv =====
// Field state registers and single-pass decode of one byte into up to two characters.
module fru_decode import fru_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] byte_in,
  input  logic       consume,
  output dec_out_t   dec
);

  logic       in_field_r, in_field_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic [5:0] remaining_r, remaining_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [3:0] carry_r, carry_nxt;

  logic [5:0] rem_dec;
  logic       last;

  assign rem_dec = remaining_r - 6'd1;
  assign last    = (rem_dec == 6'd0);

  always_comb begin
    dec           = '0;
    in_field_nxt  = in_field_r;
    kind_nxt      = kind_r;
    remaining_nxt = remaining_r;
    phase_nxt     = phase_r;
    carry_nxt     = carry_r;
    if (!in_field_r) begin
      // Header byte: open a field, or report an empty one at once.
      kind_nxt      = byte_in[7:6];
      remaining_nxt = byte_in[5:0] & LEN_MASK;
      phase_nxt     = 2'd0;
      carry_nxt     = 4'd0;
      in_field_nxt  = (remaining_nxt != 6'd0);
      if (remaining_nxt == 6'd0) begin
        dec.count = 2'd1;
        dec.r0    = '{ch: 8'h00, valid: 1'b0, kind: kind_nxt, last: 1'b1};
      end
    end else begin
      remaining_nxt = rem_dec;
      unique case (kind_r)
        KIND_ASCII8: begin
          dec.count = 2'd1;
          dec.r0    = '{ch: byte_in, valid: 1'b1, kind: kind_r, last: last};
        end
        KIND_BCD: begin
          dec.count = 2'd2;
          dec.r0 = '{ch: bcd_plus_char(byte_in[7:4]), valid: 1'b1, kind: kind_r, last: 1'b0};
          dec.r1 = '{ch: bcd_plus_char(byte_in[3:0]), valid: 1'b1, kind: kind_r, last: last};
        end
        KIND_BINARY: begin
          dec.count = 2'd2;
          dec.r0 = '{ch: hex_char(byte_in[7:4]), valid: 1'b1, kind: kind_r, last: 1'b0};
          dec.r1 = '{ch: hex_char(byte_in[3:0]), valid: 1'b1, kind: kind_r, last: last};
        end
        KIND_ASCII6: begin
          unique case (phase_r)
            2'd0: begin
              carry_nxt = {2'b00, byte_in[7:6]};
              phase_nxt = 2'd1;
              dec.r0 = '{ch: six_bit_char(byte_in[5:0]), valid: 1'b1, kind: kind_r,
                         last: 1'b0};
            end
            2'd1: begin
              carry_nxt = byte_in[7:4];
              phase_nxt = 2'd2;
              dec.r0 = '{ch: six_bit_char({byte_in[3:0], carry_r[1:0]}), valid: 1'b1,
                         kind: kind_r, last: 1'b0};
            end
            default: begin
              carry_nxt = 4'd0;
              phase_nxt = 2'd0;
              dec.r0 = '{ch: six_bit_char({byte_in[1:0], carry_r}), valid: 1'b1,
                         kind: kind_r, last: 1'b0};
            end
          endcase
          if (phase_r == 2'd2) begin
            // Third byte of a group completes two characters.
            dec.count = 2'd2;
            dec.r1 = '{ch: six_bit_char(byte_in[7:2]), valid: 1'b1, kind: kind_r,
                       last: last};
          end else if (last) begin
            // Partial group at field end: flush the leftover bits zero-padded.
            dec.count = 2'd2;
            dec.r1 = '{ch: six_bit_char({2'b00, carry_nxt}), valid: 1'b1, kind: kind_r,
                       last: 1'b1};
          end else begin
            dec.count = 2'd1;
          end
        end
        default: begin
          dec.count = 2'd0;
        end
      endcase
      if (last) begin
        in_field_nxt = 1'b0;
        phase_nxt    = 2'd0;
        carry_nxt    = 4'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_field_r  <= 1'b0;
      kind_r      <= 2'd0;
      remaining_r <= 6'd0;
      phase_r     <= 2'd0;
      carry_r     <= 4'd0;
    end else if (consume) begin
      in_field_r  <= in_field_nxt;
      kind_r      <= kind_nxt;
      remaining_r <= remaining_nxt;
      phase_r     <= phase_nxt;
      carry_r     <= carry_nxt;
    end
  end

  a_open_field_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    in_field_r |-> (remaining_r != 6'd0))
    else $error("open field with no bytes remaining");

  a_phase_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != 2'd3)
    else $error("six-bit group phase out of range");

  a_idle_state_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !in_field_r |-> (phase_r == 2'd0 && carry_r == 4'd0))
    else $error("group state left over outside a field");

  a_ascii6_only_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != 2'd0) |-> (in_field_r && kind_r == KIND_ASCII6))
    else $error("group phase advanced outside a six-bit ASCII field");

endmodule

// ===== src/fru_out_buf.sv =====
// Two-entry result buffer that sends decoded characters one word per cycle while out_tready is high.
module fru_out_buf import fru_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     load,
  input  dec_out_t dec,
  output logic     can_load,
  output logic     out_tvalid,
  input  logic     out_tready,
  output res_t     head
);

  res_t       res0_r, res0_nxt;
  res_t       res1_r, res1_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       fire;

  assign out_tvalid = (cnt_r != 2'd0);
  assign fire       = out_tvalid && out_tready;
  assign head       = res0_r;
  // New results fit when the buffer is empty or drains its last word now.
  assign can_load   = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_tready);

  always_comb begin
    res0_nxt = res0_r;
    res1_nxt = res1_r;
    cnt_nxt  = cnt_r;
    if (load) begin
      res0_nxt = dec.r0;
      res1_nxt = dec.r1;
      cnt_nxt  = dec.count;
    end else if (fire) begin
      res0_nxt = res1_r;
      cnt_nxt  = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res0_r <= res0_nxt;
    res1_r <= res1_nxt;
  end

endmodule

// ===== src/fru_field_decoder_core.sv =====
// Top level of the FRU type/length field decoder: input register, decoder, result buffer.
// Data path: an accepted byte is held in the input register and decoded from it; its
// results are registered into the result buffer, which offers them on the output.
// Throughput: one byte per cycle for headers and one-character bytes while out_tready is
// high; a two-character byte holds off the next until its first character is sent.
// Reset (rst_n low, synchronous) empties both registers and returns to expecting a header.
module fru_field_decoder_core import fru_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  // Input stream: one FRU area byte per word.
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  // Result stream: one decoded character per word.
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_char
  output logic [2:0] out_tuser,  // [0] char_valid, [2:1] field_kind
  output logic       out_tlast   // field_end
);

  // The input register holds one byte until the decoder can hand its results on.
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_consume;
  logic       can_load;

  dec_out_t   dec;
  res_t       head;

  assign s1_consume = s1_valid_r && can_load;
  assign in_tready  = !s1_valid_r || s1_consume;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      s1_valid_r <= 1'b1;
    end else if (s1_consume) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r <= in_tdata;
    end
  end

  // Decoder state advances exactly when a byte's results enter the output buffer.
  fru_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .byte_in (s1_byte_r),
    .consume (s1_consume),
    .dec     (dec)
  );

  fru_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (s1_consume),
    .dec        (dec),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .head       (head)
  );

  assign out_tdata = head.ch;
  assign out_tuser = {head.kind, head.valid};
  assign out_tlast = head.last;

endmodule
